### src/dssl_pkg.sv
// Shared types, constants and helpers for the diagonal state-space layer.
// Used by dssl_datapath and diagonal_state_space_layer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dssl_pkg;

    // Array geometry
    localparam int CHANNELS = 8;
    localparam int MODES    = 16;
    localparam int DEPTH    = CHANNELS * MODES;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GAIN_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MODE_CW  = $clog2(MODES + 1);

    // Reset value of the step register, Q0.16
    localparam logic [15:0] DT_RESET = 16'd6554;

    // Datapath widths
    localparam int P_W   = 50;                      // registered product
    localparam int T_W   = 49;                      // complex product part
    localparam int D_W   = 35;                      // rounded drive
    localparam int NR_W  = 40;                      // state update before saturation
    localparam int ACC_W = P_W + $clog2(MODES) + 2; // output accumulator
    localparam int Y_W   = ACC_W + 2;               // output sum

    // Command codes
    localparam logic [1:0] CMD_LOAD_MODE = 2'd0;
    localparam logic [1:0] CMD_LOAD_GAIN = 2'd1;
    localparam logic [1:0] CMD_SAMPLE    = 2'd2;

    // Register index decode (paddr bit 2)
    localparam logic REG_DT_STEP = 1'b0;

    // Sequencer steps
    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_DU   = 14'b00000000000010,
        S_M0   = 14'b00000000000100,
        S_M1   = 14'b00000000001000,
        S_M2   = 14'b00000000010000,
        S_M3   = 14'b00000000100000,
        S_M4   = 14'b00000001000000,
        S_M5   = 14'b00000010000000,
        S_M6   = 14'b00000100000000,
        S_M7   = 14'b00001000000000,
        S_M8   = 14'b00010000000000,
        S_GU   = 14'b00100000000000,
        S_Y1   = 14'b01000000000000,
        S_Y2   = 14'b10000000000000
    } step_t;

    // Coefficients of one mode
    typedef struct packed {
        logic signed [15:0] ar;
        logic signed [15:0] ai;
        logic signed [15:0] b;
        logic signed [15:0] cr;
        logic signed [15:0] ci;
    } coef_t;

    // Clamp to a signed 32-bit value
    function automatic logic signed [31:0] sat32(input logic signed [NR_W-1:0] v);
        logic signed [NR_W-1:0] hi;
        logic signed [NR_W-1:0] lo;
        hi = NR_W'(64'sd2147483647);
        lo = NR_W'(-64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

### src/dssl_datapath.sv
// Shared multiplier and accumulate path for the mode recurrence and output sum.
// Depends on dssl_pkg; sequenced step by step from the top level.
`timescale 1ns / 1ps
`default_nettype none

module dssl_datapath
    import dssl_pkg::*;
(
    input  wire                aclk,
    input  step_t              step,
    input  wire         [15:0] dt_step,
    input  wire  signed [15:0] u,
    input  wire  signed [15:0] gain,
    input  coef_t              coef,
    input  wire  signed [31:0] sr,
    input  wire  signed [31:0] si,
    output logic signed [31:0] nr,
    output logic signed [31:0] ni,
    output logic signed [15:0] y,
    output logic               y_sat
);

    localparam logic signed [P_W:0]  RND16 = (P_W + 1)'(32768);
    localparam logic signed [T_W:0]  RND14 = (T_W + 1)'(8192);
    localparam logic signed [Y_W:0]  RND24 = (Y_W + 1)'(8388608);
    localparam logic signed [Y_W:0]  Y_MAX = (Y_W + 1)'(32767);
    localparam logic signed [Y_W:0]  Y_MIN = (Y_W + 1)'(-32768);

    logic signed [32:0]      ma;
    logic signed [31:0]      mb;
    logic signed [64:0]      mprod;
    logic signed [P_W-1:0]   p_reg;
    logic signed [32:0]      du_reg;
    logic signed [D_W-1:0]   drv_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [31:0]      nr_reg;
    logic signed [31:0]      ni_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [Y_W-1:0]   ysum_reg;
    logic signed [P_W:0]     p_rnd;
    logic signed [T_W:0]     t_rnd;
    logic signed [NR_W-1:0]  nr_full;
    logic signed [NR_W-1:0]  ni_full;
    logic signed [Y_W:0]     y_rnd;
    logic signed [Y_W:0]     y_sh;

    // Select multiplier operands for the current step
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (step)
            S_DU: begin
                ma = $signed({17'b0, dt_step});
                mb = 32'(u);
            end
            S_M0: begin
                ma = du_reg;
                mb = 32'(coef.b);
            end
            S_M1: begin
                ma = 33'(coef.ar);
                mb = sr;
            end
            S_M2: begin
                ma = 33'(coef.ai);
                mb = si;
            end
            S_M3: begin
                ma = 33'(coef.ar);
                mb = si;
            end
            S_M4: begin
                ma = 33'(coef.ai);
                mb = sr;
            end
            S_M5: begin
                ma = 33'(coef.cr);
                mb = nr_reg;
            end
            S_M7: begin
                ma = 33'(coef.ci);
                mb = ni_reg;
            end
            S_GU: begin
                ma = 33'(gain);
                mb = 32'(u);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mprod = 65'(ma) * 65'(mb);

    // Round half up and clamp the partial results
    always_comb begin
        p_rnd   = (P_W + 1)'(p_reg) + RND16;
        t_rnd   = (T_W + 1)'(t_reg) + RND14;
        nr_full = NR_W'(t_rnd >>> 14) + NR_W'(drv_reg);
        ni_full = NR_W'(t_rnd >>> 14);
        y_rnd   = (Y_W + 1)'(ysum_reg) + RND24;
        y_sh    = y_rnd >>> 24;
        y_sat   = (y_sh > Y_MAX) || (y_sh < Y_MIN);
        if (y_sh > Y_MAX) begin
            y = 16'sh7FFF;
        end else if (y_sh < Y_MIN) begin
            y = 16'sh8000;
        end else begin
            y = y_sh[15:0];
        end
    end

    // Register each product and advance the recurrence
    always_ff @(posedge aclk) begin
        p_reg <= mprod[P_W-1:0];
        unique case (step)
            S_DU: begin
                du_reg  <= mprod[32:0];
                acc_reg <= '0;
            end
            S_M1: drv_reg <= D_W'(p_rnd >>> 16);
            S_M2: t_reg <= T_W'(p_reg);
            S_M3: t_reg <= t_reg - T_W'(p_reg);
            S_M4: begin
                nr_reg <= sat32(nr_full);
                t_reg  <= T_W'(p_reg);
            end
            S_M5: t_reg <= t_reg + T_W'(p_reg);
            S_M6: begin
                ni_reg  <= sat32(ni_full);
                acc_reg <= acc_reg + ACC_W'(p_reg);
            end
            S_M8: acc_reg <= acc_reg - ACC_W'(p_reg);
            S_Y1: ysum_reg <= (Y_W'(acc_reg) <<< 1) + (Y_W'(p_reg) <<< 12);
            default: begin
            end
        endcase
    end

    assign nr = nr_reg;
    assign ni = ni_reg;

endmodule

`default_nettype wire

### src/diagonal_state_space_layer.sv
// Top level of the diagonal state-space layer: coefficient and state memories,
// step sequencer, APB register and output word register. Uses dssl_pkg, dssl_datapath.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  | ports          | handshake        | word
//  input    | s_*            | s_valid/s_ready  | command, channel, mode, coefs, sample
//  result   | m_*            | m_valid/m_ready  | channel, output sample, clip flag
//  config   | psel/penable.. | pready always 1  | dt_step at byte address 0
//
//  A load word is stored as it is accepted. A sample word runs the DU step, then
//  one shared multiplier visits each mode in nine steps, then GU, Y1 and Y2.
//  Reset clears the mode states through per-entry valid bits; no clearing pass.
//  The block takes no word while a sample is in flight; the last step holds
//  until the output register is free.

module diagonal_state_space_layer
    import dssl_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire         [1:0]  s_cmd,
    input  wire         [2:0]  s_channel,
    input  wire         [3:0]  s_mode,
    input  wire  signed [15:0] s_decay_re,
    input  wire  signed [15:0] s_decay_im,
    input  wire  signed [15:0] s_in_weight,
    input  wire  signed [15:0] s_out_weight_re,
    input  wire  signed [15:0] s_out_weight_im,
    input  wire  signed [15:0] s_direct_gain,
    input  wire  signed [15:0] s_sample,
    input  wire                s_sequence_start,
    output logic               m_valid,
    input  wire                m_ready,
    output logic        [2:0]  m_out_channel,
    output logic signed [15:0] m_out_sample,
    output logic               m_saturated,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire         [2:0]  paddr,
    input  wire         [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    step_t               state_reg, state_next;
    logic [15:0]         dt_reg;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [MODE_CW-1:0]  cnt_reg, cnt_next;
    logic [2:0]          ch_reg;
    logic signed [15:0]  u_reg;
    logic                seq_reg;
    logic                m_valid_reg;
    logic [2:0]          m_ch_reg;
    logic signed [15:0]  m_y_reg;
    logic                m_sat_reg;
    logic [DEPTH-1:0]    st_valid_reg;

    logic [31:0]         dec_mem  [DEPTH];
    logic [47:0]         wt_mem   [DEPTH];
    logic [63:0]         st_mem   [DEPTH];
    logic [15:0]         gain_mem [CHANNELS];

    logic [31:0]         dec_q;
    logic [47:0]         wt_q;
    logic [63:0]         st_q;
    logic                st_ok_q;
    logic signed [15:0]  gain_q;

    logic                accept;
    logic                ch_ok;
    logic                mode_ok;
    logic                last_mode;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   ld_addr;
    logic [ADDR_W-1:0]   base_addr;
    logic                st_we;
    logic                out_load;
    coef_t               coef;
    logic signed [31:0]  sr, si, nr, ni;
    logic signed [15:0]  y;
    logic                y_sat;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign ch_ok     = 32'(s_channel) < CHANNELS;
    assign mode_ok   = 32'(s_mode) < MODES;
    assign base_addr = ADDR_W'(32'(s_channel) * MODES);
    assign ld_addr   = ADDR_W'(32'(s_channel) * MODES + 32'(s_mode));
    assign last_mode = (cnt_reg == MODE_CW'(MODES - 1));
    assign rd_en     = (state_reg == S_DU) || ((state_reg == S_M8) && !last_mode);
    assign rd_addr   = (state_reg == S_DU) ? addr_reg : addr_reg + ADDR_W'(1);
    assign st_we     = (state_reg == S_M8);
    assign out_load  = (state_reg == S_Y2) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && ch_ok && (s_cmd == CMD_SAMPLE)) begin
                    state_next = S_DU;
                    addr_next  = base_addr;
                    cnt_next   = '0;
                end
            end
            S_DU: state_next = S_M0;
            S_M0: state_next = S_M1;
            S_M1: state_next = S_M2;
            S_M2: state_next = S_M3;
            S_M3: state_next = S_M4;
            S_M4: state_next = S_M5;
            S_M5: state_next = S_M6;
            S_M6: state_next = S_M7;
            S_M7: state_next = S_M8;
            S_M8: begin
                if (last_mode) begin
                    state_next = S_GU;
                end else begin
                    state_next = S_M0;
                    addr_next  = addr_reg + ADDR_W'(1);
                    cnt_next   = cnt_reg + MODE_CW'(1);
                end
            end
            S_GU: state_next = S_Y1;
            S_Y1: state_next = S_Y2;
            S_Y2: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            dt_reg       <= DT_RESET;
            m_valid_reg  <= 1'b0;
            st_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            // Register write from the APB port
            if (psel && penable && pwrite && pready && (paddr[2] == REG_DT_STEP)) begin
                dt_reg <= pwdata[15:0];
            end
            // Output word register
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (st_we) begin
                st_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Hold the sample word and the output payload
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            ch_reg  <= s_channel;
            u_reg   <= s_sample;
            seq_reg <= s_sequence_start;
        end
        if (out_load) begin
            m_ch_reg  <= ch_reg;
            m_y_reg   <= y;
            m_sat_reg <= y_sat;
        end
    end

    // Coefficient, gain and state memories
    always_ff @(posedge aclk) begin
        if (accept && ch_ok && mode_ok && (s_cmd == CMD_LOAD_MODE)) begin
            dec_mem[ld_addr] <= {s_decay_re, s_decay_im};
            wt_mem[ld_addr]  <= {s_in_weight, s_out_weight_re, s_out_weight_im};
        end
        if (accept && ch_ok && (s_cmd == CMD_LOAD_GAIN)) begin
            gain_mem[GAIN_AW'(s_channel)] <= s_direct_gain;
        end
        if (st_we) begin
            st_mem[addr_reg] <= {nr, ni};
        end
        if (rd_en) begin
            dec_q   <= dec_mem[rd_addr];
            wt_q    <= wt_mem[rd_addr];
            st_q    <= st_mem[rd_addr];
            st_ok_q <= st_valid_reg[rd_addr] && !seq_reg;
        end
        if (state_reg == S_DU) begin
            gain_q <= gain_mem[GAIN_AW'(ch_reg)];
        end
    end

    assign coef = '{ar: dec_q[31:16], ai: dec_q[15:0], b: wt_q[47:32],
                    cr: wt_q[31:16], ci: wt_q[15:0]};
    assign sr   = st_ok_q ? st_q[63:32] : 32'sd0;
    assign si   = st_ok_q ? st_q[31:0]  : 32'sd0;

    dssl_datapath u_datapath (
        .aclk    (aclk),
        .step    (state_reg),
        .dt_step (dt_reg),
        .u       (u_reg),
        .gain    (gain_q),
        .coef    (coef),
        .sr      (sr),
        .si      (si),
        .nr      (nr),
        .ni      (ni),
        .y       (y),
        .y_sat   (y_sat)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_ch_reg;
    assign m_out_sample  = m_y_reg;
    assign m_saturated   = m_sat_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_DT_STEP) ? {16'b0, dt_reg} : 32'b0;

    // Sequencer stays one-hot
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // Mode counter never passes the last mode
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) < MODES)
        else $error("mode counter out of range");

    // A new output word only comes from the final step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_Y2))
        else $error("output word raised outside final step");

    // State write-back stays inside the channel being processed
    a_wb_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        st_we |-> (32'(addr_reg) / MODES == 32'(ch_reg)))
        else $error("state write outside current channel");

endmodule

`default_nettype wire

### dv/diagonal_state_space_layer_test.sv
// Self-checking testbench for the diagonal state-space layer: drives load and sample
// words, predicts each output word from its own copy of the coefficients and mode states.
// Depends on dssl_pkg and diagonal_state_space_layer.
`timescale 1ns / 1ps

module diagonal_state_space_layer_test;
    import dssl_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         DRAIN_CYCLES = 400;
    localparam longint     CYCLE_LIMIT  = 10000000;

    typedef struct {
        logic [1:0]         cmd;
        logic [2:0]         ch;
        logic [3:0]         md;
        logic signed [15:0] ar, ai, b, cr, ci, d, u;
        logic               start;
    } ssm_word_t;

    typedef struct {
        logic [2:0]         ch;
        logic signed [15:0] y;
        logic               sat;
    } ssm_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    wire  s_ready;
    logic [1:0] s_cmd = '0;
    logic [2:0] s_channel = '0;
    logic [3:0] s_mode = '0;
    logic signed [15:0] s_decay_re = '0, s_decay_im = '0, s_in_weight = '0;
    logic signed [15:0] s_out_weight_re = '0, s_out_weight_im = '0;
    logic signed [15:0] s_direct_gain = '0, s_sample = '0;
    logic s_sequence_start = 1'b0;
    wire  m_valid;
    logic m_ready = 1'b0;
    wire  [2:0] m_out_channel;
    wire  signed [15:0] m_out_sample;
    wire  m_saturated;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire  pready;

    diagonal_state_space_layer dut (.*);

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of coefficients, gains, mode states and step
    logic signed [15:0] decay_re_q[DEPTH], decay_im_q[DEPTH], in_w_q[DEPTH];
    logic signed [15:0] out_re_q[DEPTH], out_im_q[DEPTH];
    logic signed [15:0] gain_q[CHANNELS];
    longint             mode_re_q[DEPTH], mode_im_q[DEPTH];
    logic [15:0]        step_q = DT_RESET;

    ssm_word_t pending_words[$];
    ssm_out_t  expected_outs[$];
    int        errors = 0;
    longint    cycles = 0;

    function automatic longint round_down_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advance the predictor by one accepted word
    task automatic advance_layer(input ssm_word_t w);
        int       k;
        longint   uu, acc, drive, nr, ni, y;
        ssm_out_t r;
        case (w.cmd)
            CMD_LOAD_MODE: begin
                k = w.ch * MODES + w.md;
                decay_re_q[k] = w.ar; decay_im_q[k] = w.ai; in_w_q[k] = w.b;
                out_re_q[k] = w.cr;   out_im_q[k] = w.ci;
            end
            CMD_LOAD_GAIN: gain_q[w.ch] = w.d;
            CMD_SAMPLE: begin
                uu = longint'(w.u);
                acc = 0;
                for (int n = 0; n < MODES; n++) begin
                    k = w.ch * MODES + n;
                    if (w.start) begin
                        mode_re_q[k] = 0;
                        mode_im_q[k] = 0;
                    end
                    drive = round_down_shift(longint'(step_q) * longint'(in_w_q[k]) * uu, 16);
                    nr = round_down_shift(longint'(decay_re_q[k]) * mode_re_q[k]
                                          - longint'(decay_im_q[k]) * mode_im_q[k], 14) + drive;
                    ni = round_down_shift(longint'(decay_re_q[k]) * mode_im_q[k]
                                          + longint'(decay_im_q[k]) * mode_re_q[k], 14);
                    mode_re_q[k] = clamp32(nr);
                    mode_im_q[k] = clamp32(ni);
                    acc += longint'(out_re_q[k]) * mode_re_q[k]
                           - longint'(out_im_q[k]) * mode_im_q[k];
                end
                y = round_down_shift(2 * acc + longint'(gain_q[w.ch]) * uu * 4096, 24);
                r.ch = w.ch;
                r.sat = 1'b0;
                if (y > 32767) begin
                    y = 32767; r.sat = 1'b1;
                end else if (y < -32768) begin
                    y = -32768; r.sat = 1'b1;
                end
                r.y = 16'(y);
                expected_outs = {expected_outs, r};
            end
            default: ;
        endcase
    endtask

    // Input driver: bursts of random length separated by random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        ssm_word_t w;
        logic      nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                advance_layer(pending_words.pop_front());
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_words.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    w = pending_words[0];
                    s_cmd <= w.cmd; s_channel <= w.ch; s_mode <= w.md;
                    s_decay_re <= w.ar; s_decay_im <= w.ai; s_in_weight <= w.b;
                    s_out_weight_re <= w.cr; s_out_weight_im <= w.ci;
                    s_direct_gain <= w.d; s_sample <= w.u; s_sequence_start <= w.start;
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
                    end
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // Result monitor and receiver stall pattern
    int stall_mode = 0;
    always @(posedge aclk) begin
        ssm_out_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected word ch=%0d y=%0d sat=%0d", $time,
                         m_out_channel, m_out_sample, m_saturated);
                errors++;
            end else begin
                e = expected_outs.pop_front();
                if (m_out_channel !== e.ch) begin
                    $display("%0t: channel expected %0d actual %0d", $time, e.ch, m_out_channel);
                    errors++;
                end
                if (m_out_sample !== e.y) begin
                    $display("%0t: sample expected %0d actual %0d", $time, e.y, m_out_sample);
                    errors++;
                end
                if (m_saturated !== e.sat) begin
                    $display("%0t: saturated expected %0d actual %0d", $time, e.sat, m_saturated);
                    errors++;
                end
            end
        end
        if (cycles % 3000 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ((cycles % 400) > 300);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Stimulus side bookkeeping: which coefficients have been loaded
    logic [MODES-1:0] mode_loaded[CHANNELS];
    logic             gain_loaded[CHANNELS];

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_word(input ssm_word_t w);
        if (w.cmd == CMD_LOAD_MODE) mode_loaded[w.ch][w.md] = 1'b1;
        if (w.cmd == CMD_LOAD_GAIN) gain_loaded[w.ch] = 1'b1;
        pending_words = {pending_words, w};
    endtask

    function automatic ssm_word_t noise_word(input logic [1:0] cmd, input logic [2:0] ch);
        ssm_word_t w;
        w.cmd = cmd; w.ch = ch; w.md = 4'($urandom);
        w.ar = pick16(); w.ai = pick16();
        // keep many decays stable so state builds up over a sequence
        if ($urandom_range(0, 1) == 1) begin
            w.ar = 16'($urandom_range(0, 30000)) - 16'sd15000;
            w.ai = 16'($urandom_range(0, 12000)) - 16'sd6000;
        end
        w.b = pick16(); w.cr = pick16(); w.ci = pick16(); w.d = pick16();
        w.u = pick16(); w.start = 1'($urandom);
        return w;
    endfunction

    function automatic logic channel_ready(input int ch);
        return (&mode_loaded[ch]) && gain_loaded[ch];
    endfunction

    // Write one configuration register over APB
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr[2] == REG_DT_STEP) step_q = data[15:0];
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_valid || expected_outs.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        ssm_word_t w;
        int        ch, len;
        int        made;
        made = 0;
        while (made < count) begin
            ch = $urandom_range(0, CHANNELS - 1);
            if (!channel_ready(ch) || $urandom_range(0, 9) == 0) begin
                // fill a channel's coefficients
                w = noise_word(CMD_LOAD_MODE, 3'(ch));
                if (!gain_loaded[ch] || $urandom_range(0, 4) == 0) w.cmd = CMD_LOAD_GAIN;
                queue_word(w);
                made++;
            end else if ($urandom_range(0, 19) == 0) begin
                queue_word(noise_word(CMD_RESERVED, 3'(ch)));
                made++;
            end else begin
                // well-formed sequence on one channel
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    w = noise_word(CMD_SAMPLE, 3'(ch));
                    w.start = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
                    queue_word(w);
                    made++;
                end
            end
        end
    endtask

    initial begin
        ssm_word_t w;
        logic [15:0] steps[6];
        for (int c = 0; c < CHANNELS; c++) begin
            mode_loaded[c] = '0;
            gain_loaded[c] = 1'b0;
        end
        for (int k = 0; k < DEPTH; k++) begin
            mode_re_q[k] = 0;
            mode_im_q[k] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        steps[0] = DT_RESET; steps[1] = 16'hFFFF; steps[2] = 16'h0000;
        steps[3] = 16'h0001; steps[4] = 16'h8000; steps[5] = 16'($urandom);

        // directed: extreme coefficients on channel 0, saturating inputs, reserved command
        for (int m = 0; m < MODES; m++) begin
            w = noise_word(CMD_LOAD_MODE, 3'd0);
            w.md = 4'(m);
            w.ar = (m == 0) ? 16'sh7FFF : (m == 1) ? 16'sh8000 : 16'sh3FFF;
            w.ai = (m == 0) ? 16'sh7FFF : (m == 1) ? 16'sh8000 : 16'sh0000;
            w.b  = (m[0]) ? 16'sh8000 : 16'sh7FFF;
            w.cr = (m[0]) ? 16'sh8000 : 16'sh7FFF;
            w.ci = (m[0]) ? 16'sh7FFF : 16'sh8000;
            queue_word(w);
        end
        w = noise_word(CMD_LOAD_GAIN, 3'd0); w.d = 16'sh7FFF; queue_word(w);
        w = noise_word(CMD_SAMPLE, 3'd0); w.u = 16'sh7FFF; w.start = 1'b1; queue_word(w);
        w = noise_word(CMD_SAMPLE, 3'd0); w.u = 16'sh7FFF; w.start = 1'b0; queue_word(w);
        w = noise_word(CMD_SAMPLE, 3'd0); w.u = 16'sh8000; w.start = 1'b0; queue_word(w);
        w = noise_word(CMD_RESERVED, 3'd7); queue_word(w);
        w = noise_word(CMD_LOAD_GAIN, 3'd0); w.d = 16'sh8000; queue_word(w);
        w = noise_word(CMD_SAMPLE, 3'd0); w.u = 16'sh0000; w.start = 1'b1; queue_word(w);
        w = noise_word(CMD_SAMPLE, 3'd0); w.u = 16'sh8000; w.start = 1'b0; queue_word(w);

        // random phases, one step setting each, written while the block is idle
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            apb_write({REG_DT_STEP, 2'b00}, {16'h0, steps[p]});
            random_phase(310);
        end
        wait_idle();
        if (errors == 0 && expected_outs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### diagonal_state_space_layer.f
src/dssl_pkg.sv
src/dssl_datapath.sv
src/diagonal_state_space_layer.sv
dv/diagonal_state_space_layer_test.sv
